>>> rtl/core/dpms_pkg.sv
// Shared types, codes and constants of the dashboard power mode sequencer.
// No dependencies; every other file of the block imports this package.
package dpms_pkg;

  // Bus event kinds as they arrive on the command field.
  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_IGNITION    = 4'd1,
    EV_TANK        = 4'd2,
    EV_ODOMETER    = 4'd3,
    EV_RPM         = 4'd4,
    EV_SPEED       = 4'd5,
    EV_CONSUMPTION = 4'd6,
    EV_GEAR        = 4'd7,
    EV_HANDBRAKE   = 4'd8,
    EV_OTHER       = 4'd9
  } ev_e;

  localparam logic [3:0] CMD_MAX = 4'd9;

  typedef enum logic [2:0] {
    MODE_SLEEP   = 3'd0,
    MODE_CONFIRM = 3'd1,
    MODE_BOOT    = 3'd2,
    MODE_CLIMAX  = 3'd3,
    MODE_RUN     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    PAGE_BLANK   = 2'd0,
    PAGE_STARTUP = 2'd1,
    PAGE_PARKED  = 2'd2,
    PAGE_DRIVE   = 2'd3
  } page_e;

  typedef enum logic [1:0] {
    OUTC_NONE  = 2'd0,
    OUTC_IDLE  = 2'd1,
    OUTC_DRIVE = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    SHOW_NONE        = 3'd0,
    SHOW_TANK        = 3'd1,
    SHOW_ODOMETER    = 3'd2,
    SHOW_RPM         = 3'd3,
    SHOW_SPEED       = 3'd4,
    SHOW_CONSUMPTION = 3'd5,
    SHOW_GEAR        = 3'd6
  } show_e;

  typedef enum logic [1:0] {
    SB_NONE = 2'd0,
    SB_64MS = 2'd1,
    SB_32MS = 2'd2,
    SB_16MS = 2'd3
  } standby_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CONFIRM_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_BOOT_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_RPM_ABSENT_LIMIT = 2'd2;
  localparam logic [1:0] CFG_CLIMAX_DURATION  = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Capture bits for classes that are not tracked by the waiting mask.
  localparam logic [3:0] CAP_RPM_BRAKE = 4'b0001;
  localparam logic [3:0] CAP_SPEED     = 4'b0010;
  localparam logic [3:0] CAP_CONSUMPT  = 4'b0100;

  localparam logic [1:0] WAIT_FUEL = 2'b01;
  localparam logic [1:0] WAIT_ODO  = 2'b10;
  localparam logic [1:0] WAIT_ALL  = 2'b11;

  localparam logic [3:0] PTS_MAJOR = 4'd3;
  localparam logic [3:0] PTS_MINOR = 4'd1;
  localparam logic [7:0] STALE_MAX = 8'hFF;

  // Queue between the front and the back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [15:0] confirm_timeout;
    logic [15:0] boot_timeout;
    logic [7:0]  rpm_absent_limit;
    logic [15:0] climax_duration;
  } cfg_t;

  // One classified bus event.
  typedef struct packed {
    ev_e         kind;
    logic        nz;
    logic [31:0] value;
    logic [7:0]  ms;
  } ev_t;

  // One result word.
  typedef struct packed {
    mode_e       mode;
    page_e       page;
    logic [7:0]  warp;
    outcome_e    outcome;
    show_e       show_kind;
    logic [31:0] show_value;
    standby_e    standby;
    logic        display_on;
  } res_t;

  // points * 255 / 11, saturated at 255.
  function automatic logic [7:0] warp_of(input logic [3:0] pts);
    logic [7:0] w;
    case (pts)
      4'd0:    w = 8'd0;
      4'd1:    w = 8'd23;
      4'd2:    w = 8'd46;
      4'd3:    w = 8'd69;
      4'd4:    w = 8'd92;
      4'd5:    w = 8'd115;
      4'd6:    w = 8'd139;
      4'd7:    w = 8'd162;
      4'd8:    w = 8'd185;
      4'd9:    w = 8'd208;
      4'd10:   w = 8'd231;
      default: w = 8'd255;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/dashboard_power_mode_sequencer_unit.sv
// Top level of the dashboard power mode sequencer: configuration registers,
// front classifier, event queue and mode back end. Depends on dpms_pkg.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+--------------------------------------
//   bus event | in_valid_i / in_stall_o   | cmd_i, event_value_i, ms_elapsed_i
//   result    | out_valid_o / out_stall_i | mode_o .. display_on_o, one per event
//   config    | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One event a cycle is sustained while the result side does not stall; each
// accepted event is registered first in a queue entry, then in the result
// register of the back end. The back end updates the mode once per event.
// Reset puts the block in sleep with default timeouts and an empty queue.
// A stalled result holds; the two-entry queue keeps taking events until full.
module dashboard_power_mode_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [3:0]                     cmd_i,
  input  logic [31:0]                    event_value_i,
  input  logic [7:0]                     ms_elapsed_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     mode_o,
  output logic [1:0]                     page_o,
  output logic [7:0]                     warp_o,
  output logic [1:0]                     outcome_o,
  output logic [2:0]                     show_kind_o,
  output logic [31:0]                    show_value_o,
  output logic [1:0]                     standby_code_o,
  output logic                           display_on_o,
  input  logic                           cfg_we_i,
  input  logic [dpms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpms_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dpms_pkg::*;

  cfg_t cfg_q;
  ev_t  front_ev;
  ev_t  head_ev;
  res_t res;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.confirm_timeout  <= 16'd64;
      cfg_q.boot_timeout     <= 16'd200;
      cfg_q.rpm_absent_limit <= 8'd16;
      cfg_q.climax_duration  <= 16'd1500;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONFIRM_TIMEOUT:  cfg_q.confirm_timeout  <= cfg_data_i;
        CFG_BOOT_TIMEOUT:     cfg_q.boot_timeout     <= cfg_data_i;
        CFG_RPM_ABSENT_LIMIT: cfg_q.rpm_absent_limit <= cfg_data_i[7:0];
        CFG_CLIMAX_DURATION:  cfg_q.climax_duration  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dpms_front u_front (
    .in_valid_i    (in_valid_i),
    .cmd_i         (cmd_i),
    .event_value_i (event_value_i),
    .ms_elapsed_i  (ms_elapsed_i),
    .q_full_i      (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .ev_o          (front_ev)
  );

  dpms_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ev_i (front_ev),
    .pop_i     (pop),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .head_o    (head_ev)
  );

  dpms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ev_valid_i  (q_valid),
    .ev_i        (head_ev),
    .ev_pop_o    (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign mode_o         = res.mode;
  assign page_o         = res.page;
  assign warp_o         = res.warp;
  assign outcome_o      = res.outcome;
  assign show_kind_o    = res.show_kind;
  assign show_value_o   = res.show_value;
  assign standby_code_o = res.standby;
  assign display_on_o   = res.display_on;

endmodule

>>> rtl/core/dpms_front.sv
// Front of the sequencer: accepts bus events and classifies them.
// Depends on dpms_pkg; feeds dpms_queue.
module dpms_front (
  input  logic              in_valid_i,
  input  logic [3:0]        cmd_i,
  input  logic [31:0]       event_value_i,
  input  logic [7:0]        ms_elapsed_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output dpms_pkg::ev_t     ev_o
);
  import dpms_pkg::*;

  always_comb begin
    // Codes above the known range behave like an ordinary "other" event.
    if (cmd_i <= CMD_MAX) begin
      ev_o.kind = ev_e'(cmd_i);
    end else begin
      ev_o.kind = EV_OTHER;
    end
    ev_o.nz    = |event_value_i;
    ev_o.value = event_value_i;
    ev_o.ms    = ms_elapsed_i;
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

>>> rtl/core/dpms_queue.sv
// Short event queue that decouples the front from the back.
// Depends on dpms_pkg for the event type and the depth.
module dpms_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dpms_pkg::ev_t   push_ev_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output dpms_pkg::ev_t   head_o
);
  import dpms_pkg::*;

  ev_t                 store_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end
    if (pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_ev_i;
    end
  end

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = store_q[rd_ptr_q];

endmodule

>>> rtl/core/dpms_back.sv
// Back of the sequencer: mode state machine and the registered result word.
// Depends on dpms_pkg; takes events from dpms_queue.
module dpms_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpms_pkg::cfg_t  cfg_i,
  input  logic            ev_valid_i,
  input  dpms_pkg::ev_t   ev_i,
  output logic            ev_pop_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output dpms_pkg::res_t  res_o
);
  import dpms_pkg::*;

  mode_e       mode_q, mode_d;
  page_e       page_q, page_d;
  outcome_e    outc_q, outc_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  cap_q, cap_d;
  logic [3:0]  pts_q, pts_d;
  logic [1:0]  wait_q, wait_d;
  logic        eng_q, eng_d;
  logic        brk_q, brk_d;
  logic [7:0]  stale_q, stale_d;
  logic [15:0] climax_q, climax_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;

  logic        pop;
  logic        run_off;
  logic [16:0] climax_sum;
  show_e       show_kind;
  logic [31:0] show_value;
  standby_e    standby;

  assign pop        = ev_valid_i && (!out_valid_q || !out_stall_i);
  assign climax_sum = {1'b0, climax_q} + {9'd0, ev_i.ms};

  always_comb begin
    mode_d     = mode_q;
    page_d     = page_q;
    outc_d     = outc_q;
    tick_d     = tick_q;
    cap_d      = cap_q;
    pts_d      = pts_q;
    wait_d     = wait_q;
    eng_d      = eng_q;
    brk_d      = brk_q;
    stale_d    = stale_q;
    climax_d   = climax_q;
    run_off    = 1'b0;
    show_kind  = SHOW_NONE;
    show_value = '0;
    standby    = SB_NONE;

    if (pop) begin
      // Any non-empty word wakes the block and counts as the first confirm word.
      if (mode_q == MODE_SLEEP && ev_i.kind != EV_NONE) begin
        mode_d = MODE_CONFIRM;
        tick_d = '0;
      end

      case (mode_d)
        MODE_CONFIRM: begin
          if (ev_i.kind == EV_IGNITION && ev_i.nz) begin
            mode_d = MODE_BOOT;
            page_d = PAGE_STARTUP;
            outc_d = OUTC_NONE;
            cap_d  = '0;
            pts_d  = '0;
            wait_d = WAIT_ALL;
            eng_d  = 1'b0;
            brk_d  = 1'b0;
            tick_d = '0;
          end else begin
            if (ev_i.kind == EV_NONE) begin
              standby = SB_64MS;
            end
            tick_d = tick_d + 16'd1;
            if (tick_d >= cfg_i.confirm_timeout) begin
              mode_d = MODE_SLEEP;
              page_d = PAGE_BLANK;
              outc_d = OUTC_NONE;
            end
          end
        end

        MODE_BOOT: begin
          case (ev_i.kind)
            EV_TANK: begin
              show_kind  = SHOW_TANK;
              show_value = ev_i.value;
              if ((wait_q & WAIT_FUEL) != '0) begin
                wait_d = wait_q & ~WAIT_FUEL;
                pts_d  = pts_q + PTS_MAJOR;
              end
            end
            EV_ODOMETER: begin
              show_kind  = SHOW_ODOMETER;
              show_value = ev_i.value;
              if ((wait_q & WAIT_ODO) != '0) begin
                wait_d = wait_q & ~WAIT_ODO;
                pts_d  = pts_q + PTS_MAJOR;
              end
            end
            EV_RPM, EV_HANDBRAKE: begin
              if (ev_i.kind == EV_RPM) begin
                eng_d = ev_i.nz;
              end else begin
                brk_d = ev_i.nz;
              end
              if ((cap_q & CAP_RPM_BRAKE) == '0) begin
                cap_d = cap_q | CAP_RPM_BRAKE;
                pts_d = pts_q + PTS_MAJOR;
              end
            end
            EV_SPEED: begin
              if ((cap_q & CAP_SPEED) == '0) begin
                cap_d = cap_q | CAP_SPEED;
                pts_d = pts_q + PTS_MINOR;
              end
            end
            EV_CONSUMPTION: begin
              if ((cap_q & CAP_CONSUMPT) == '0) begin
                cap_d = cap_q | CAP_CONSUMPT;
                pts_d = pts_q + PTS_MINOR;
              end
            end
            EV_IGNITION: begin
              if (!ev_i.nz) begin
                mode_d = MODE_SLEEP;
                page_d = PAGE_BLANK;
                outc_d = OUTC_NONE;
              end
            end
            EV_NONE: begin
              tick_d = tick_q + 16'd1;
              if (tick_d >= cfg_i.boot_timeout) begin
                wait_d = '0;
              end
            end
            default: begin
            end
          endcase
          // Boot hands over once fuel and odometer are in, or on timeout.
          if (mode_d == MODE_BOOT && wait_d == '0) begin
            mode_d   = MODE_CLIMAX;
            outc_d   = (eng_d && !brk_d) ? OUTC_DRIVE : OUTC_IDLE;
            climax_d = '0;
          end
        end

        MODE_CLIMAX: begin
          if (ev_i.kind == EV_IGNITION && !ev_i.nz) begin
            mode_d = MODE_SLEEP;
            page_d = PAGE_BLANK;
            outc_d = OUTC_NONE;
          end else begin
            climax_d = climax_sum[16] ? 16'hFFFF : climax_sum[15:0];
            if (climax_d >= cfg_i.climax_duration) begin
              mode_d  = MODE_RUN;
              eng_d   = 1'b0;
              brk_d   = 1'b0;
              stale_d = '0;
            end
          end
        end

        MODE_RUN: begin
          case (ev_i.kind)
            EV_RPM: begin
              eng_d      = ev_i.nz;
              stale_d    = '0;
              show_kind  = SHOW_RPM;
              show_value = ev_i.value;
            end
            EV_SPEED: begin
              show_kind  = SHOW_SPEED;
              show_value = ev_i.value;
            end
            EV_TANK: begin
              show_kind  = SHOW_TANK;
              show_value = ev_i.value;
            end
            EV_ODOMETER: begin
              show_kind  = SHOW_ODOMETER;
              show_value = ev_i.value;
            end
            EV_CONSUMPTION: begin
              show_kind  = SHOW_CONSUMPTION;
              show_value = ev_i.value;
            end
            EV_GEAR: begin
              show_kind  = SHOW_GEAR;
              show_value = ev_i.value;
            end
            EV_HANDBRAKE: begin
              brk_d = ev_i.nz;
            end
            EV_IGNITION: begin
              run_off = !ev_i.nz;
            end
            EV_NONE: begin
              // The stale counter stops at its top; rpm is dropped at the limit.
              if (stale_q < STALE_MAX) begin
                stale_d = stale_q + 8'd1;
                if (stale_d >= cfg_i.rpm_absent_limit) begin
                  eng_d = 1'b0;
                end
              end
              standby = (page_q == PAGE_DRIVE) ? SB_16MS : SB_32MS;
            end
            default: begin
            end
          endcase
          if (run_off) begin
            mode_d = MODE_SLEEP;
            page_d = PAGE_BLANK;
            outc_d = OUTC_NONE;
          end else begin
            page_d = (eng_d && !brk_d) ? PAGE_DRIVE : PAGE_PARKED;
          end
        end

        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_d            = res_q;
    res_d.mode       = mode_d;
    res_d.page       = page_d;
    res_d.warp       = (mode_d == MODE_BOOT || mode_d == MODE_CLIMAX) ? warp_of(pts_d) : '0;
    res_d.outcome    = (mode_d == MODE_CLIMAX || mode_d == MODE_RUN) ? outc_d : OUTC_NONE;
    res_d.show_kind  = show_kind;
    res_d.show_value = show_value;
    res_d.standby    = standby;
    res_d.display_on = (mode_d == MODE_BOOT || mode_d == MODE_CLIMAX || mode_d == MODE_RUN);

    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SLEEP;
      page_q      <= PAGE_BLANK;
      outc_q      <= OUTC_NONE;
      tick_q      <= '0;
      cap_q       <= '0;
      pts_q       <= '0;
      wait_q      <= WAIT_ALL;
      eng_q       <= 1'b0;
      brk_q       <= 1'b0;
      stale_q     <= '0;
      climax_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      page_q      <= page_d;
      outc_q      <= outc_d;
      tick_q      <= tick_d;
      cap_q       <= cap_d;
      pts_q       <= pts_d;
      wait_q      <= wait_d;
      eng_q       <= eng_d;
      brk_q       <= brk_d;
      stale_q     <= stale_d;
      climax_q    <= climax_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result word is loaded only with a new event, so it holds while stalled.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign ev_pop_o    = pop;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/dpms_checker.sv
// Port-level checks for the dashboard power mode sequencer, and the bind
// that attaches them to the top level. Depends on dpms_pkg.
module dpms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  mode_o,
  input logic [1:0]  page_o,
  input logic [7:0]  warp_o,
  input logic [1:0]  outcome_o,
  input logic        display_on_o
);
  import dpms_pkg::*;

  // A stalled result word stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result word keeps its mode and page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mode_o) && $stable(page_o))
    else $error("result changed while stalled");

  // Warp only shows during boot and climax.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && warp_o != 8'd0 |->
      mode_o == MODE_BOOT || mode_o == MODE_CLIMAX)
    else $error("warp outside boot");

  // With the screen off there is neither a page nor an outcome.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !display_on_o |-> page_o == PAGE_BLANK && outcome_o == OUTC_NONE)
    else $error("page or outcome while screen off");

endmodule

bind dashboard_power_mode_sequencer_unit dpms_checker u_dpms_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .mode_o       (mode_o),
  .page_o       (page_o),
  .warp_o       (warp_o),
  .outcome_o    (outcome_o),
  .display_on_o (display_on_o)
);
